// ===== sv/trld_pkg.sv =====
// Package for the TGA run-length pixel decoder.
// Types, register indexes and constants shared by the top, register and unpack files; no dependencies.
package trld_pkg;

  typedef enum logic {
    CMD_STREAM  = 1'b0,
    CMD_PALETTE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_PIXEL_BYTES  = 2'd0,
    REG_RLE_MODE     = 2'd1,
    REG_PALETTE_MODE = 2'd2,
    REG_IMAGE_PIXELS = 2'd3
  } cfg_reg_e;

  localparam logic [2:0]  PIXEL_BYTES_RST  = 3'd3;
  localparam logic [31:0] IMAGE_PIXELS_RST = 32'd1;
  localparam logic [7:0]  HDR_LEN_MASK     = 8'h7f;
  localparam logic [7:0]  HDR_RUN_FLAG     = 8'h80;

  typedef struct packed {
    logic [2:0]  pixel_bytes;
    logic        rle_mode;
    logic        palette_mode;
    logic [31:0] image_pixels;
  } cfg_t;

  // Register write event: restart the image with this pixel count.
  typedef struct packed {
    logic        restart;
    logic [31:0] reload;
  } cfg_evt_t;

  // Pixel finished by the byte on the input.
  typedef struct packed {
    logic        fire;
    logic [31:0] value;
    logic [7:0]  count;
    logic        done;
  } pix_t;

endpackage

// ===== sv/trld_ifs.sv =====
// Handshake interfaces of the TGA run-length pixel decoder.
// Input item, result item and register write channels; no dependencies.
interface trld_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  stream_byte;
  logic [7:0]  entry_index;
  logic [31:0] entry_color;

  modport source (output valid, cmd, stream_byte, entry_index, entry_color, input ready);
  modport sink   (input valid, cmd, stream_byte, entry_index, entry_color, output ready);
endinterface

interface trld_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [7:0]  repeat_count;
  logic        image_done;

  modport source (output valid, pixel_value, repeat_count, image_done, input ready);
  modport sink   (input valid, pixel_value, repeat_count, image_done, output ready);
endinterface

interface trld_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/tga_rle_pixel_decoder.sv =====
// TGA run-length pixel decoder, top level.
// Result valid in the cycle after a pixel's last byte; one item per cycle unless stalled.
// The palette read and the result register load on the same edge that accepts the byte.
// Input stalls only while the result register is full and not being taken.
// Reset (rst_ni low, async) clears decode state and loads register defaults;
// palette contents are undefined until written.
module tga_rle_pixel_decoder #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  trld_cfg_if.sink  cfg_i,
  trld_in_if.sink   item_i,
  trld_out_if.source result_o
);

  localparam int IW = $clog2(PALETTE_DEPTH);

  trld_pkg::cfg_t     cfg;
  trld_pkg::cfg_evt_t evt;
  trld_pkg::pix_t     pix;
  logic [IW-1:0]      rd_index;
  logic [31:0]        idx_ext;

  logic        in_accept;
  logic        byte_acc;
  logic        pal_wr;
  logic        load;
  logic [31:0] rd_data;

  logic        vld_q;
  logic [31:0] raw_q;
  logic [7:0]  cnt_q;
  logic        done_q;
  logic        pal_q;

  trld_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg),
    .evt_o  (evt)
  );

  assign item_i.ready = !vld_q || result_o.ready;
  assign in_accept    = item_i.valid && item_i.ready;
  assign byte_acc     = in_accept && (trld_pkg::cmd_e'(item_i.cmd) == trld_pkg::CMD_STREAM);
  assign idx_ext      = 32'(item_i.entry_index);
  // Writes at or beyond the depth are dropped.
  assign pal_wr       = in_accept && (trld_pkg::cmd_e'(item_i.cmd) == trld_pkg::CMD_PALETTE) &&
                        (idx_ext < 32'(PALETTE_DEPTH));
  assign load         = byte_acc && pix.fire;

  trld_unpack #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .IW            (IW)
  ) u_unpack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .evt_i    (evt),
    .accept_i (byte_acc),
    .byte_i   (item_i.stream_byte),
    .pix_o    (pix),
    .index_o  (rd_index)
  );

  trld_palette #(
    .DEPTH (PALETTE_DEPTH),
    .IW    (IW)
  ) u_palette (
    .clk_i     (clk_i),
    .wr_en_i   (pal_wr),
    .wr_addr_i (idx_ext[IW-1:0]),
    .wr_data_i (item_i.entry_color),
    .rd_en_i   (load && cfg.palette_mode),
    .rd_addr_i (rd_index),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (item_i.ready) begin
      vld_q <= load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      raw_q  <= pix.value;
      cnt_q  <= pix.count;
      done_q <= pix.done;
      pal_q  <= cfg.palette_mode;
    end
  end

  assign result_o.valid        = vld_q;
  assign result_o.pixel_value  = pal_q ? rd_data : raw_q;
  assign result_o.repeat_count = cnt_q;
  assign result_o.image_done   = done_q;

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.repeat_count != 8'd0))
    else $error("result with zero repeat count");

  a_palette_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (trld_pkg::cmd_e'(item_i.cmd) == trld_pkg::CMD_PALETTE))
      |=> !$rose(result_o.valid))
    else $error("palette write produced a result");

  a_count_fits_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (32'(pix.count) <= (cfg.image_pixels == 32'd0 ? 32'd1 : cfg.image_pixels)))
    else $error("repeat count exceeds image size");

endmodule

// ===== sv/trld_cfg_regs.sv =====
// Configuration registers of the TGA run-length pixel decoder.
// Depends on trld_pkg and trld_cfg_if.
module trld_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  trld_cfg_if.sink           cfg_i,
  output trld_pkg::cfg_t     cfg_o,
  output trld_pkg::cfg_evt_t evt_o
);

  trld_pkg::cfg_t cfg_q;
  logic           wr;
  logic [31:0]    px_next;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid;
  assign cfg_o       = cfg_q;

  // Pixel count the restart must load, including the one being written now.
  always_comb begin
    px_next = (trld_pkg::cfg_reg_e'(cfg_i.index) == trld_pkg::REG_IMAGE_PIXELS) ?
              cfg_i.data : cfg_q.image_pixels;
    evt_o.restart = wr;
    evt_o.reload  = (px_next == 32'd0) ? 32'd1 : px_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_bytes  <= trld_pkg::PIXEL_BYTES_RST;
      cfg_q.rle_mode     <= 1'b0;
      cfg_q.palette_mode <= 1'b0;
      cfg_q.image_pixels <= trld_pkg::IMAGE_PIXELS_RST;
    end else if (wr) begin
      case (trld_pkg::cfg_reg_e'(cfg_i.index))
        trld_pkg::REG_PIXEL_BYTES:  cfg_q.pixel_bytes  <= cfg_i.data[2:0];
        trld_pkg::REG_RLE_MODE:     cfg_q.rle_mode     <= cfg_i.data[0];
        trld_pkg::REG_PALETTE_MODE: cfg_q.palette_mode <= cfg_i.data[0];
        trld_pkg::REG_IMAGE_PIXELS: cfg_q.image_pixels <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/trld_unpack.sv =====
// Packet and pixel assembly of the TGA run-length pixel decoder.
// Tracks header, packet and image counters; depends on trld_pkg.
module trld_unpack #(
  parameter int PALETTE_DEPTH = 256,
  parameter int IW            = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trld_pkg::cfg_t     cfg_i,
  input  trld_pkg::cfg_evt_t evt_i,
  input  logic               accept_i,
  input  logic [7:0]         byte_i,
  output trld_pkg::pix_t     pix_o,
  output logic [IW-1:0]      index_o
);

  localparam int  RW       = IW + 9;
  localparam bit  IS_POW2  = (PALETTE_DEPTH & (PALETTE_DEPTH - 1)) == 0;
  // Weight of each byte position modulo the palette depth.
  localparam int  W0 = 1 % PALETTE_DEPTH;
  localparam int  W1 = 256 % PALETTE_DEPTH;
  localparam int  W2 = 65536 % PALETTE_DEPTH;
  localparam int  W3 = 16777216 % PALETTE_DEPTH;

  logic          expect_q, expect_d;
  logic          run_q, run_d;
  logic [7:0]    left_q, left_d;
  logic [1:0]    pos_q, pos_d;
  logic [31:0]   acc_q, acc_d;
  logic [IW-1:0] res_q, res_d;
  logic [31:0]   px_q, px_d;

  logic          hdr;
  logic [1:0]    term_pos;
  logic [1:0]    pos_inc;
  logic [31:0]   acc_new;
  logic [IW-1:0] w_sel;
  logic [RW-1:0] res_sum;
  logic [IW-1:0] res_new;
  logic [7:0]    cnt_raw, cnt_nz, cnt;
  logic [7:0]    left_nx;
  logic          expect_nx;
  logic [31:0]   px_nx;

  always_comb begin
    case (cfg_i.pixel_bytes)
      3'd0, 3'd1: term_pos = 2'd1;
      3'd2:       term_pos = 2'd2;
      3'd3:       term_pos = 2'd3;
      default:    term_pos = 2'd0; // four bytes wrap the position to zero
    endcase
    case (pos_q)
      2'd0:    w_sel = IW'(W0);
      2'd1:    w_sel = IW'(W1);
      2'd2:    w_sel = IW'(W2);
      default: w_sel = IW'(W3);
    endcase
  end

  // Running residue of the pixel value modulo the depth; sum stays below 256 * depth.
  always_comb begin
    res_sum = RW'(byte_i) * RW'(w_sel) + RW'(res_q);
    for (int k = 7; k >= 0; k--) begin
      if (res_sum >= (RW'(PALETTE_DEPTH) << k)) res_sum = res_sum - (RW'(PALETTE_DEPTH) << k);
    end
    res_new = res_sum[IW-1:0];
  end

  always_comb begin
    hdr     = cfg_i.rle_mode && expect_q;
    acc_new = acc_q | (32'(byte_i) << {pos_q, 3'b000});
    pos_inc = pos_q + 2'd1;

    cnt_raw   = 8'd1;
    left_nx   = left_q;
    expect_nx = expect_q;
    if (cfg_i.rle_mode) begin
      if (run_q) begin
        cnt_raw = left_q;
        left_nx = 8'd0;
      end else if (left_q != 8'd0) begin
        left_nx = left_q - 8'd1;
      end
      if (left_nx == 8'd0) expect_nx = 1'b1;
    end
    cnt_nz = (cnt_raw == 8'd0) ? 8'd1 : cnt_raw;
    // Clamp the run to the pixels left in the image.
    cnt    = (32'(cnt_nz) > px_q) ? px_q[7:0] : cnt_nz;
    px_nx  = px_q - 32'(cnt);

    pix_o.fire  = !hdr && (pos_inc == term_pos);
    pix_o.value = acc_new;
    pix_o.count = cnt;
    pix_o.done  = (px_nx == 32'd0);
    index_o     = IS_POW2 ? acc_new[IW-1:0] : res_new;
  end

  always_comb begin
    expect_d = expect_q;
    run_d    = run_q;
    left_d   = left_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    res_d    = res_q;
    px_d     = px_q;
    if (evt_i.restart) begin
      expect_d = 1'b1;
      run_d    = 1'b0;
      left_d   = 8'd0;
      pos_d    = 2'd0;
      acc_d    = 32'd0;
      res_d    = '0;
      px_d     = evt_i.reload;
    end else if (accept_i) begin
      if (hdr) begin
        run_d    = (byte_i & trld_pkg::HDR_RUN_FLAG) != 8'd0;
        left_d   = (byte_i & trld_pkg::HDR_LEN_MASK) + 8'd1;
        expect_d = 1'b0;
        pos_d    = 2'd0;
        acc_d    = 32'd0;
        res_d    = '0;
      end else if (!pix_o.fire) begin
        pos_d = pos_inc;
        acc_d = acc_new;
        res_d = res_new;
      end else if (pix_o.done) begin
        expect_d = 1'b1;
        run_d    = 1'b0;
        left_d   = 8'd0;
        pos_d    = 2'd0;
        acc_d    = 32'd0;
        res_d    = '0;
        px_d     = (cfg_i.image_pixels == 32'd0) ? 32'd1 : cfg_i.image_pixels;
      end else begin
        left_d   = left_nx;
        expect_d = expect_nx;
        pos_d    = 2'd0;
        acc_d    = 32'd0;
        res_d    = '0;
        px_d     = px_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b1;
      run_q    <= 1'b0;
      left_q   <= 8'd0;
      pos_q    <= 2'd0;
      acc_q    <= 32'd0;
      res_q    <= '0;
      px_q     <= trld_pkg::IMAGE_PIXELS_RST;
    end else begin
      expect_q <= expect_d;
      run_q    <= run_d;
      left_q   <= left_d;
      pos_q    <= pos_d;
      acc_q    <= acc_d;
      res_q    <= res_d;
      px_q     <= px_d;
    end
  end

endmodule

// ===== sv/trld_palette.sv =====
// Palette memory of the TGA run-length pixel decoder.
// One write port, one registered read port; no dependencies.
module trld_palette #(
  parameter int DEPTH = 256,
  parameter int IW    = 8
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  logic [31:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [IW-1:0] rd_addr_i,
  output logic [31:0]   rd_data_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_q;

  assign rd_data_o = rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_q <= mem[rd_addr_i];
  end

endmodule

// ===== tb/sv/tga_rle_pixel_decoder_tb.sv =====
// Self-checking testbench for the TGA run-length pixel decoder.
// Drives byte stream, palette loads and register writes with random idling and checks every pixel.
// Depends on trld_pkg, the trld interfaces and tga_rle_pixel_decoder.
module tga_rle_pixel_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAL_DEPTH     = 256;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 65;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 300;

  typedef struct {
    trld_pkg::cmd_e cmd;
    logic [7:0]     stream_byte;
    logic [7:0]     entry_index;
    logic [31:0]    entry_color;
  } dec_item_t;

  typedef struct {
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        image_done;
  } pixel_out_t;

  // Tracks decoder state and the queue of pixels still owed by the block.
  class pixel_scoreboard;
    logic [2:0]  cfg_pixel_bytes;
    bit          cfg_rle;
    bit          cfg_palette;
    logic [31:0] cfg_image_pixels;
    bit          want_header;
    bit          in_run;
    int unsigned packet_left;
    int unsigned byte_pos;
    logic [31:0] pixel_acc;
    logic [31:0] pixels_left;
    logic [31:0] palette [PAL_DEPTH];
    pixel_out_t  pixels_q[$];
    int          errors;

    function new();
      cfg_pixel_bytes  = trld_pkg::PIXEL_BYTES_RST;
      cfg_rle          = 1'b0;
      cfg_palette      = 1'b0;
      cfg_image_pixels = trld_pkg::IMAGE_PIXELS_RST;
      errors           = 0;
      restart();
    endfunction

    function void restart();
      want_header = 1'b1;
      in_run      = 1'b0;
      packet_left = 0;
      byte_pos    = 0;
      pixel_acc   = '0;
      pixels_left = (cfg_image_pixels == '0) ? 32'd1 : cfg_image_pixels;
    endfunction

    function int unsigned pixel_width();
      if (cfg_pixel_bytes == 3'd0) begin
        return 1;
      end
      if (cfg_pixel_bytes > 3'd4) begin
        return 4;
      end
      return int'(cfg_pixel_bytes);
    endfunction

    function void write_reg(trld_pkg::cfg_reg_e idx, logic [31:0] data);
      case (idx)
        trld_pkg::REG_PIXEL_BYTES:  cfg_pixel_bytes  = data[2:0];
        trld_pkg::REG_RLE_MODE:     cfg_rle          = data[0];
        trld_pkg::REG_PALETTE_MODE: cfg_palette      = data[0];
        trld_pkg::REG_IMAGE_PIXELS: cfg_image_pixels = data;
        default: ;
      endcase
      restart();
    endfunction

    function void note_item(dec_item_t it);
      logic [31:0] value;
      int unsigned count;
      pixel_out_t  res;
      if (it.cmd == trld_pkg::CMD_PALETTE) begin
        if (int'(it.entry_index) < PAL_DEPTH) begin
          palette[it.entry_index] = it.entry_color;
        end
        return;
      end
      if (cfg_rle && want_header) begin
        in_run      = (it.stream_byte & trld_pkg::HDR_RUN_FLAG) != 8'd0;
        packet_left = int'(it.stream_byte & trld_pkg::HDR_LEN_MASK) + 1;
        want_header = 1'b0;
        byte_pos    = 0;
        pixel_acc   = '0;
        return;
      end
      pixel_acc = pixel_acc | ({24'd0, it.stream_byte} << (8 * byte_pos));
      byte_pos++;
      if (byte_pos != pixel_width()) begin
        return;
      end
      value     = pixel_acc;
      pixel_acc = '0;
      byte_pos  = 0;
      if (cfg_palette) begin
        value = palette[value % PAL_DEPTH];
      end
      count = 1;
      if (cfg_rle) begin
        if (in_run) begin
          count       = packet_left;
          packet_left = 0;
        end else if (packet_left > 0) begin
          packet_left--;
        end
        if (packet_left == 0) begin
          want_header = 1'b1;
        end
      end
      // a run never reaches past the end of the image
      if (count > pixels_left) begin
        count = pixels_left;
      end
      pixels_left      = pixels_left - count;
      res.pixel_value  = value;
      res.repeat_count = 8'(count);
      res.image_done   = (pixels_left == '0);
      pixels_q.push_back(res);
      if (pixels_left == '0) begin
        restart();
      end
    endfunction

    function void check_result(pixel_out_t got);
      pixel_out_t want;
      if (pixels_q.size() == 0) begin
        $error("result with no pixel pending: value %h count %0d done %0b",
               got.pixel_value, got.repeat_count, got.image_done);
        errors++;
        return;
      end
      want = pixels_q.pop_front();
      if (got.pixel_value !== want.pixel_value) begin
        $error("pixel_value: expected %h, got %h", want.pixel_value, got.pixel_value);
        errors++;
      end
      if (got.repeat_count !== want.repeat_count) begin
        $error("repeat_count: expected %0d, got %0d", want.repeat_count, got.repeat_count);
        errors++;
      end
      if (got.image_done !== want.image_done) begin
        $error("image_done: expected %0b, got %0b", want.image_done, got.image_done);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  trld_cfg_if cfg_if ();
  trld_in_if  item_if ();
  trld_out_if res_if ();

  tga_rle_pixel_decoder #(
    .PALETTE_DEPTH(PAL_DEPTH)
  ) u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .item_i   (item_if),
    .result_o (res_if)
  );

  pixel_scoreboard sb;
  dec_item_t       feed_q[$];
  int              sender_sent = 0;
  bit              sender_calm = 1'b0;
  int              cycle_cnt = 0;
  logic [2:0]      width_plan [RANDOM_PHASES];

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tga_rle_pixel_decoder test failed");
      $finish;
    end
  end

  function automatic void push_byte(logic [7:0] b);
    dec_item_t it;
    it.cmd         = trld_pkg::CMD_STREAM;
    it.stream_byte = b;
    it.entry_index = 8'($urandom_range(0, 255));
    it.entry_color = $urandom();
    feed_q.push_back(it);
  endfunction

  function automatic void push_entry(logic [7:0] idx, logic [31:0] color);
    dec_item_t it;
    it.cmd         = trld_pkg::CMD_PALETTE;
    it.stream_byte = 8'($urandom_range(0, 255));
    it.entry_index = idx;
    it.entry_color = color;
    feed_q.push_back(it);
  endfunction

  // Mostly well-formed packets with random content, some stray bytes and palette loads.
  function automatic void gen_stream(int n);
    int unsigned r;
    int unsigned len;
    int unsigned npix;
    int unsigned width;
    bit          run;
    width = sb.pixel_width();
    while (feed_q.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        push_entry(8'($urandom_range(0, 255)), $urandom());
      end else if (!sb.cfg_rle || r < 12) begin
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        run = 1'($urandom_range(0, 1));
        // long raw packets only with one-byte pixels to keep the item count down
        if ($urandom_range(0, 9) == 0 && (run || width == 1)) begin
          len = $urandom_range(0, 127);
        end else begin
          len = $urandom_range(0, 3);
        end
        push_byte({run, 7'(len)});
        npix = run ? 1 : len + 1;
        repeat (npix * width) push_byte(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  function automatic int sender_gap();
    if (sender_sent % 50 == 0) begin
      sender_calm = ($urandom_range(0, 3) == 0);
    end
    sender_sent++;
    return sender_calm ? 0 : int'($urandom_range(0, 19));
  endfunction

  task automatic send_feed();
    dec_item_t it;
    int        gap;
    while (feed_q.size() != 0) begin
      it  = feed_q.pop_front();
      gap = sender_gap();
      if (gap > 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      item_if.cmd         <= it.cmd;
      item_if.stream_byte <= it.stream_byte;
      item_if.entry_index <= it.entry_index;
      item_if.entry_color <= it.entry_color;
      item_if.valid       <= 1'b1;
      @(posedge clk_i);
      while (!item_if.ready) @(posedge clk_i);
      sb.note_item(it);
      @(negedge clk_i);
    end
    item_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Leaves valid high; the caller drops it after the last write.
  task automatic cfg_write(trld_pkg::cfg_reg_e idx, logic [31:0] data);
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    cfg_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic set_config(logic [2:0] pb, bit rle, bit pal, logic [31:0] pixels);
    cfg_write(trld_pkg::REG_PIXEL_BYTES, {29'd0, pb});
    cfg_write(trld_pkg::REG_RLE_MODE, {31'd0, rle});
    cfg_write(trld_pkg::REG_PALETTE_MODE, {31'd0, pal});
    cfg_write(trld_pkg::REG_IMAGE_PIXELS, pixels);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait for every owed pixel, then let bytes still in flight drain.
  task automatic settle();
    while (sb.pixels_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    logic [31:0] pixels;
    sb = new();
    width_plan = '{3'd1, 3'd1, 3'd3, 3'd4, 3'd2, 3'd6, 3'd2, 3'd3, 3'd7, 3'd4, 3'd1, 3'd1};
    rst_ni              <= 1'b0;
    item_if.valid       <= 1'b0;
    item_if.cmd         <= trld_pkg::CMD_STREAM;
    item_if.stream_byte <= 8'd0;
    item_if.entry_index <= 8'd0;
    item_if.entry_color <= 32'd0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= trld_pkg::REG_PIXEL_BYTES;
    cfg_if.data         <= 32'd0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset defaults: 3-byte raw pixels, one-pixel image
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    send_feed();

    // zero image size acts as one pixel; a full 128 run is clamped to it
    settle();
    set_config(3'd4, 1'b1, 1'b0, 32'd0);
    push_byte(8'hff);
    repeat (4) push_byte(8'hff);
    send_feed();

    // zero pixel bytes act as one; clamped run, then a raw packet cut by image end
    settle();
    set_config(3'd0, 1'b1, 1'b0, 32'd3);
    push_byte(8'h01);
    push_byte(8'h11);
    push_entry(8'hff, 32'hffffffff);
    push_byte(8'h22);
    push_byte(8'h83);
    push_byte(8'haa);
    push_byte(8'h05);
    push_byte(8'h01);
    push_byte(8'h02);
    push_byte(8'h03);
    push_byte(8'h81);
    push_byte(8'h44);
    send_feed();

    // pixel bytes above four act as four; palette lookup on the low byte
    settle();
    set_config(3'd5, 1'b0, 1'b1, 32'hffffffff);
    push_entry(8'h00, 32'h00000000);
    push_byte(8'hff);
    push_byte(8'h12);
    push_byte(8'h34);
    push_byte(8'h56);
    repeat (4) push_byte(8'h00);
    push_byte(8'h00);
    send_feed();

    // load the whole palette so no lookup ever hits an unwritten entry
    for (int i = 0; i < PAL_DEPTH; i++) begin
      push_entry(8'(i), $urandom());
    end
    send_feed();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 6)
        0:       pixels = $urandom_range(1, 12);
        1:       pixels = 32'hffffffff;
        2:       pixels = 32'd0;
        3:       pixels = 32'd1;
        4:       pixels = $urandom();
        default: pixels = $urandom_range(20, 300);
      endcase
      // the restart on a write may drop a partial pixel left by the last phase
      settle();
      set_config(width_plan[p], p[0], p[1], pixels);
      gen_stream(PHASE_ITEMS);
      send_feed();
    end

    settle();
    if (sb.errors == 0) begin
      $display("tga_rle_pixel_decoder test passed");
    end else begin
      $display("tga_rle_pixel_decoder test failed");
    end
    $finish;
  end

  // Result side: random stalls, calm stretches and one long hold-off.
  initial begin
    int         gap;
    int         taken;
    bit         calm;
    pixel_out_t got;
    taken = 0;
    calm  = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 40 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      gap = calm ? 0 : int'($urandom_range(0, 19));
      if (taken == HOLD_AT) begin
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      got.pixel_value  = res_if.pixel_value;
      got.repeat_count = res_if.repeat_count;
      got.image_done   = res_if.image_done;
      sb.check_result(got);
      taken++;
      @(negedge clk_i);
    end
  end

endmodule
